@@ rtl/core/at_response_detector_macros.svh @@
// assertion macros for the at response detector
// expects clk_i and rst_ni in the scope of each use
`ifndef AT_RESPONSE_DETECTOR_MACROS_SVH
`define AT_RESPONSE_DETECTOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define AT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define AT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/at_resp_pkg.sv @@
// shared types and reply patterns for the at response detector
// no dependencies
package at_resp_pkg;

  localparam int WIN_KEPT = 16;
  localparam int WIN_FULL = 17;

  typedef logic [7:0] byte_t;

  typedef enum logic [1:0] {
    VERDICT_WAIT  = 2'd0,
    VERDICT_OK    = 2'd1,
    VERDICT_ERROR = 2'd2
  } verdict_e;

  localparam logic [1:0] MODE_PLAIN  = 2'd0;
  localparam logic [1:0] MODE_PROMPT = 2'd1;
  localparam logic [1:0] MODE_CLOSE  = 2'd2;

  localparam byte_t CHAR_CR = 8'd13;
  localparam byte_t CHAR_LF = 8'd10;

  localparam int OK_LEN      = 4;
  localparam int ERROR_LEN   = 7;
  localparam int PROMPT_LEN  = 1;
  localparam int CONNECT_LEN = 17;
  localparam int CLOSED_LEN  = 7;

  localparam byte_t PAT_OK [OK_LEN] = '{"O", "K", CHAR_CR, CHAR_LF};
  localparam byte_t PAT_ERROR [ERROR_LEN] = '{"E", "R", "R", "O", "R", CHAR_CR, CHAR_LF};
  localparam byte_t PAT_PROMPT [PROMPT_LEN] = '{">"};
  localparam byte_t PAT_CONNECT [CONNECT_LEN] = '{
    "A", "L", "R", "E", "A", "D", "Y", " ",
    "C", "O", "N", "N", "E", "C", "T", CHAR_CR, CHAR_LF};
  localparam byte_t PAT_CLOSED [CLOSED_LEN] = '{"C", "L", "O", "S", "E", "D", CHAR_CR};

  // tail hits of the window against each reply
  typedef struct packed {
    logic ok;
    logic error;
    logic prompt;
    logic connect;
    logic closed;
  } match_t;

endpackage

@@ rtl/core/at_response_detector.sv @@
// at response detector top level: input register, window compare, result register
// depends on at_resp_pkg, at_resp_hist, at_resp_match and the assertion macros
//
// Classifies modem replies one received byte per item. An item with tuser set
// starts a new exchange: the 16-byte history and the verdict are cleared and
// the result is "waiting". Any other item is a received byte; the newest 17
// characters are matched at their tail against OK, ALREADY CONNECT, the send
// prompt, CLOSED and ERROR in that priority order, filtered by reply_mode
// (0 plain, 1 send prompt, 2 request close, 3 only ALREADY CONNECT). The first
// success or error verdict holds until the next start. Every item yields one
// result carrying the verdict after that item. Throughput is one item per
// clock unless m_axis_tready_i stalls the result stream; an item passes the
// input register, then the result register around the single compare stage.
// The history and verdict update in the same cycle the item enters the result
// register, so back-to-back items see each other's effect. reply_mode is
// written by cfg_we_i and should only change while the block is idle.
`include "at_response_detector_macros.svh"

module at_response_detector import at_resp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,     // reply_mode
  // input stream
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,  // [7:0] rx_byte
  input  logic       s_axis_tuser_i,  // [0] command
  // result stream
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o   // [1:0] verdict, [7:2] zero
);

  // reply mode register
  logic [1:0] mode_q;

  // input register
  logic  in_valid_q, in_valid_d;
  logic  in_cmd_q;
  byte_t in_byte_q;

  // result register
  logic     out_valid_q, out_valid_d;
  verdict_e out_verdict_q;

  // latched verdict of the current exchange
  verdict_e verdict_q, verdict_d, verdict_next;

  byte_t  hist [WIN_KEPT];
  match_t hits;

  logic advance;
  logic accept_in;

  // item moves from the input register into the result register
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign accept_in       = s_axis_tvalid_i && s_axis_tready_o;

  at_resp_hist u_hist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (advance && !in_cmd_q),
    .clear_i (advance && in_cmd_q),
    .byte_i  (in_byte_q),
    .hist_o  (hist)
  );

  at_resp_match u_match (
    .hist_i  (hist),
    .byte_i  (in_byte_q),
    .match_o (hits)
  );

  // priority of the reply checks, only while still waiting
  always_comb begin
    verdict_next = verdict_q;
    if (verdict_q == VERDICT_WAIT) begin
      priority if (mode_q == MODE_PLAIN && hits.ok) begin
        verdict_next = VERDICT_OK;
      end else if (hits.connect) begin
        verdict_next = VERDICT_OK;
      end else if (mode_q == MODE_PROMPT && hits.prompt) begin
        verdict_next = VERDICT_OK;
      end else if (mode_q == MODE_CLOSE && hits.closed) begin
        verdict_next = VERDICT_OK;
      end else if (mode_q == MODE_PLAIN && hits.error) begin
        verdict_next = VERDICT_ERROR;
      end else begin
        verdict_next = VERDICT_WAIT;
      end
    end
  end

  // start command clears the verdict
  assign verdict_d = in_cmd_q ? VERDICT_WAIT : verdict_next;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept_in) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_PLAIN;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      verdict_q   <= VERDICT_WAIT;
    end else begin
      if (cfg_we_i) mode_q <= cfg_wdata_i;
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) verdict_q <= verdict_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      in_cmd_q  <= s_axis_tuser_i;
      in_byte_q <= s_axis_tdata_i;
    end
    if (advance) out_verdict_q <= verdict_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, out_verdict_q};

  // a latched verdict survives further received bytes
  `AT_ASSERT_NXT(a_verdict_holds,
    advance && !in_cmd_q && verdict_q != VERDICT_WAIT,
    verdict_q == $past(verdict_q), "verdict changed after being latched")

  // start command clears the verdict
  `AT_ASSERT_NXT(a_start_clears, advance && in_cmd_q,
    verdict_q == VERDICT_WAIT && out_verdict_q == VERDICT_WAIT,
    "start command did not clear the verdict")

  // the result shows the verdict the item left behind
  `AT_ASSERT_NXT(a_result_matches_state, advance,
    out_valid_q && out_verdict_q == verdict_q, "result differs from latched verdict")

  // empty input register always takes an item
  `AT_ASSERT_IMP(a_ready_when_empty, !in_valid_q, s_axis_tready_o,
    "input stalled with empty input register")

endmodule

@@ rtl/core/at_resp_hist.sv @@
// history of the last received bytes, oldest first
// depends on at_resp_pkg
module at_resp_hist import at_resp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  shift_i,
  input  logic  clear_i,
  input  byte_t byte_i,
  output byte_t hist_o [WIN_KEPT]
);

  byte_t hist_q [WIN_KEPT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WIN_KEPT; k++) hist_q[k] <= '0;
    end else if (clear_i) begin
      for (int k = 0; k < WIN_KEPT; k++) hist_q[k] <= '0;
    end else if (shift_i) begin
      for (int k = 0; k < WIN_KEPT - 1; k++) hist_q[k] <= hist_q[k+1];
      hist_q[WIN_KEPT-1] <= byte_i;
    end
  end

  assign hist_o = hist_q;

endmodule

@@ rtl/core/at_resp_match.sv @@
// parallel tail compare of the byte window against the fixed replies
// depends on at_resp_pkg
module at_resp_match import at_resp_pkg::*; (
  input  byte_t  hist_i [WIN_KEPT],
  input  byte_t  byte_i,
  output match_t match_o
);

  byte_t win [WIN_FULL];

  always_comb begin
    for (int k = 0; k < WIN_KEPT; k++) win[k] = hist_i[k];
    win[WIN_KEPT] = byte_i;
  end

  always_comb begin
    match_o = '1;
    for (int k = 0; k < OK_LEN; k++)
      if (win[WIN_FULL-OK_LEN+k] != PAT_OK[k]) match_o.ok = 1'b0;
    for (int k = 0; k < ERROR_LEN; k++)
      if (win[WIN_FULL-ERROR_LEN+k] != PAT_ERROR[k]) match_o.error = 1'b0;
    for (int k = 0; k < PROMPT_LEN; k++)
      if (win[WIN_FULL-PROMPT_LEN+k] != PAT_PROMPT[k]) match_o.prompt = 1'b0;
    for (int k = 0; k < CONNECT_LEN; k++)
      if (win[WIN_FULL-CONNECT_LEN+k] != PAT_CONNECT[k]) match_o.connect = 1'b0;
    for (int k = 0; k < CLOSED_LEN; k++)
      if (win[WIN_FULL-CLOSED_LEN+k] != PAT_CLOSED[k]) match_o.closed = 1'b0;
  end

endmodule
